### hdl/tsht_pkg.sv
// Types and constants shared by the text span hit table.
package tsht_pkg;

    localparam int COL_W = 10;
    localparam int ROW_W = 12;
    localparam int IDX_W = 5;
    localparam int NUM_W = 6;
    localparam int IN_W  = 72;
    localparam int OUT_W = 56;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_HIT   = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0] r1;
        logic [COL_W-1:0] c1;
        logic [ROW_W-1:0] r0;
        logic [COL_W-1:0] c0;
    } t_span;

    typedef struct packed {
        logic             pad;
        logic [IDX_W-1:0] entry_index;
        logic [ROW_W-1:0] end_row;
        logic [COL_W-1:0] end_col;
        logic [ROW_W-1:0] start_row;
        logic [COL_W-1:0] start_col;
        logic [ROW_W-1:0] query_row;
        logic [COL_W-1:0] query_col;
    } t_in_word;

    typedef struct packed {
        logic                table_full;
        logic signed [12:0]  bound_end_row;
        logic signed [10:0]  bound_end_col;
        logic signed [12:0]  bound_start_row;
        logic signed [10:0]  bound_start_col;
        logic                found;
        logic [NUM_W-1:0]    hit_number;
    } t_result;

    localparam t_result RES_NONE = '{
        table_full:      1'b0,
        bound_end_row:   13'h1FFF,
        bound_end_col:   11'h7FF,
        bound_start_row: 13'h1FFF,
        bound_start_col: 11'h7FF,
        found:           1'b0,
        hit_number:      '0
    };

endpackage

### hdl/tsht_span_match.sv
// Containment test of one grid point against one stored span.
module tsht_span_match (
    input  tsht_pkg::t_span                i_span,
    input  logic [tsht_pkg::COL_W-1:0]     i_col,
    input  logic [tsht_pkg::ROW_W-1:0]     i_row,
    output logic                           o_hit
);
    import tsht_pkg::*;

    logic on_r0;
    logic on_r1;
    logic col_ge;
    logic col_lt;

    assign on_r0  = (i_row == i_span.r0);
    assign on_r1  = (i_row == i_span.r1);
    assign col_ge = (i_col >= i_span.c0);
    assign col_lt = (i_col < i_span.c1);

    always_comb begin
        if (i_span.r0 == i_span.r1) begin
            o_hit = on_r0 && col_ge && col_lt;
        end else begin
            o_hit = (on_r0 && col_ge) || (on_r1 && col_lt) ||
                    ((i_row > i_span.r0) && (i_row < i_span.r1));
        end
    end

endmodule

### hdl/text_span_hit_table.sv
// Top level: span table in a single-port-read memory with an in-order hit scan.
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid/tready        tuser: func; tdata: query, span, index
//  m_axis   out  m_axis_tvalid/tready        tdata: number, found, bounds, full
//
// The hit test checks the stored spans in order and stops at the first hit or at the
// last span: the scan reads one entry per cycle from the span memory.
// Synchronous active-low reset empties the table; memory contents are not
// cleared. A new word is taken when the previous one is finished, while its
// result may still wait in the output register.
module text_span_hit_table #(
    parameter int MAX_REGIONS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [9:0] query_col, [21:10] query_row, [31:22] start_col, [43:32] start_row,
    // [53:44] end_col, [65:54] end_row, [70:66] entry_index, [71] zero
    input  logic [tsht_pkg::IN_W-1:0]     s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] hit_number, [6] found, [17:7] bound_start_col, [30:18] bound_start_row,
    // [41:31] bound_end_col, [54:42] bound_end_row, [55] table_full
    output logic [tsht_pkg::OUT_W-1:0]    m_axis_tdata
);
    import tsht_pkg::*;

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [COL_W-1:0] r_qcol, n_qcol;
    logic [ROW_W-1:0] r_qrow, n_qrow;
    t_result r_res, n_res;
    logic r_ov;
    t_result r_out;

    t_span r_mem [MAX_REGIONS];
    t_span r_rd_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic wr_en;
    t_span wr_data;

    t_in_word in_word;
    t_func in_func;
    logic s_fire;
    logic load_out;
    logic hit;
    logic scan_last;
    logic idx_ok;
    logic tbl_room;

    assign in_word  = t_in_word'(s_axis_tdata);
    assign in_func  = t_func'(s_axis_tuser);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign load_out = (r_state == ST_DONE) && (!r_ov || m_axis_tready);
    assign idx_ok   = (XW'(in_word.entry_index) < XW'(r_count));
    assign tbl_room = (r_count < CW'(MAX_REGIONS));
    assign scan_last = (({1'b0, r_idx} + (CW+1)'(1)) >= {1'b0, r_count});

    tsht_span_match u_match (
        .i_span (r_rd_data),
        .i_col  (r_qcol),
        .i_row  (r_qrow),
        .o_hit  (hit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    case (in_func)
                        FUNC_HIT:  n_state = (r_count == '0) ? ST_DONE : ST_SCAN;
                        FUNC_READ: n_state = idx_ok ? ST_READ : ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit || scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_qcol  = r_qcol;
        n_qrow  = r_qrow;
        n_res   = r_res;
        rd_addr = AW'(r_idx + CW'(1));
        wr_en   = 1'b0;
        wr_addr = AW'(r_count);
        wr_data = '{r1: in_word.end_row, c1: in_word.end_col,
                    r0: in_word.start_row, c0: in_word.start_col};
        case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (s_fire) begin
                    n_res = RES_NONE;
                    case (in_func)
                        FUNC_ADD: begin
                            if (tbl_room) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_res.table_full = 1'b1;
                            end
                        end
                        FUNC_CLEAR: n_count = '0;
                        FUNC_HIT: begin
                            n_idx  = '0;
                            n_qcol = in_word.query_col;
                            n_qrow = in_word.query_row;
                        end
                        default: begin
                            rd_addr = AW'(in_word.entry_index);
                            n_idx   = CW'(in_word.entry_index);
                        end
                    endcase
                end
            end
            ST_SCAN, ST_READ: begin
                if ((r_state == ST_READ) || hit) begin
                    n_res.table_full      = 1'b0;
                    n_res.hit_number      = NUM_W'(r_idx + CW'(1));
                    n_res.found           = 1'b1;
                    n_res.bound_start_col = $signed({1'b0, r_rd_data.c0});
                    n_res.bound_start_row = $signed({1'b0, r_rd_data.r0});
                    n_res.bound_end_col   = $signed({1'b0, r_rd_data.c1});
                    n_res.bound_end_row   = $signed({1'b0, r_rd_data.r1});
                end else if (!scan_last) begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_qcol <= n_qcol;
        r_qrow <= n_qrow;
        r_res  <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_W'(r_out);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_REGIONS))
        else $error("span count beyond table size");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && (in_func == FUNC_ADD) && tbl_room |=> r_count == $past(r_count) + CW'(1))
        else $error("accepted add did not grow the table");

    a_full_no_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.table_full && r_out.found))
        else $error("dropped add reported as found");

    a_none_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_out.found |-> (r_out.hit_number == '0) &&
            (r_out.bound_start_col == -11'sd1) && (r_out.bound_end_row == -13'sd1))
        else $error("miss result carries span data");

endmodule
